### rtl/dsp_pkg.sv
// Shared types and constants for the date string parser and validator.
package dsp_pkg;

  localparam int unsigned ChW    = 8;
  localparam int unsigned MonAccW = 10;
  localparam int unsigned DayAccW = 10;
  localparam int unsigned YearAccW = 17;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned OutDataW = 24;

  localparam logic [ChW-1:0] ChSlash = 8'h2f;
  localparam logic [ChW-1:0] ChZero  = 8'h30;
  localparam logic [ChW-1:0] ChNine  = 8'h39;

  localparam logic [1:0] SlashNone = 2'd0;
  localparam logic [1:0] SlashOne  = 2'd1;
  localparam logic [1:0] SlashMax  = 2'd2;

  localparam logic [MonAccW-1:0]  FieldLimit = 10'd100;
  localparam logic [YearAccW-1:0] YearLimit  = 17'd10000;
  localparam logic [YearAccW-1:0] CenturyBase = 17'd2000;

  localparam logic [YearW-1:0] ResetYear = 14'd1900;

  typedef struct packed {
    logic [MonAccW-1:0]  month;
    logic [DayAccW-1:0]  day;
    logic [YearAccW-1:0] year;
    logic                bad;
  } parse_t;

  typedef struct packed {
    logic             ok;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
  } check_t;

endpackage

### rtl/dsp_accum.sv
// Character parser: slash counting and month, day and year accumulators.
module dsp_accum
  import dsp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           beat,
  input  logic [ChW-1:0] ch,
  input  logic           end_marker,
  output parse_t         cur
);

  logic [MonAccW-1:0]  month_acc, month_acc_next;
  logic [DayAccW-1:0]  day_acc, day_acc_next;
  logic [YearAccW-1:0] year_acc, year_acc_next;
  logic [1:0]          slash_count, slash_count_next;
  logic                bad_flag, bad_flag_next;
  logic [3:0]          dig;
  logic                any_full;

  assign dig = ch[3:0] - ChZero[3:0];
  // any field at its digit limit blocks further digits, whichever field they target
  assign any_full = (month_acc >= FieldLimit) || (day_acc >= FieldLimit) ||
                    (year_acc >= YearLimit);

  always_comb begin
    month_acc_next   = month_acc;
    day_acc_next     = day_acc;
    year_acc_next    = year_acc;
    slash_count_next = slash_count;
    bad_flag_next    = bad_flag;
    if (end_marker) begin
      month_acc_next   = '0;
      day_acc_next     = '0;
      year_acc_next    = '0;
      slash_count_next = SlashNone;
      bad_flag_next    = 1'b0;
    end else if (!bad_flag) begin
      if (ch == ChSlash) begin
        if (slash_count >= SlashMax) begin
          bad_flag_next = 1'b1;
        end else begin
          slash_count_next = slash_count + 2'd1;
        end
      end else if (ch < ChZero || ch > ChNine || any_full) begin
        bad_flag_next = 1'b1;
      end else begin
        priority if (slash_count == SlashNone) begin
          month_acc_next = (month_acc << 3) + (month_acc << 1) + MonAccW'(dig);
        end else if (slash_count == SlashOne) begin
          day_acc_next = (day_acc << 3) + (day_acc << 1) + DayAccW'(dig);
        end else begin
          year_acc_next = (year_acc << 3) + (year_acc << 1) + YearAccW'(dig);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      month_acc   <= '0;
      day_acc     <= '0;
      year_acc    <= '0;
      slash_count <= SlashNone;
      bad_flag    <= 1'b0;
    end else if (beat) begin
      month_acc   <= month_acc_next;
      day_acc     <= day_acc_next;
      year_acc    <= year_acc_next;
      slash_count <= slash_count_next;
      bad_flag    <= bad_flag_next;
    end
  end

  assign cur.month = month_acc;
  assign cur.day   = day_acc;
  assign cur.year  = year_acc;
  assign cur.bad   = bad_flag;

endmodule

### rtl/dsp_check.sv
// Calendar check of the parsed fields and two-digit year expansion.
module dsp_check
  import dsp_pkg::*;
(
  input  parse_t cur,
  output check_t res
);

  logic                m_ok, d_ok, short_mon, feb, year_ok, leap;
  logic [YearAccW-1:0] year_full;

  assign m_ok      = (cur.month >= 10'd1) && (cur.month <= 10'd12);
  assign d_ok      = (cur.day >= 10'd1) && (cur.day <= 10'd31);
  assign short_mon = (cur.month == 10'd4) || (cur.month == 10'd6) ||
                     (cur.month == 10'd9) || (cur.month == 10'd11);
  assign feb       = (cur.month == 10'd2);
  // 2000 is a multiple of four, so the raw year's low bits decide
  assign leap      = (cur.year[1:0] == 2'b00);
  assign year_ok   = (cur.year < YearLimit);
  assign year_full = (cur.year < YearAccW'(FieldLimit)) ? cur.year + CenturyBase : cur.year;

  assign res.ok = !cur.bad && m_ok && d_ok &&
                  !(short_mon && cur.day > 10'd30) &&
                  !(feb && cur.day > 10'd29) &&
                  !(feb && !leap && cur.day == 10'd29) &&
                  year_ok;
  assign res.day   = cur.day[DayW-1:0];
  assign res.month = cur.month[MonW-1:0];
  assign res.year  = year_full[YearW-1:0];

endmodule

### rtl/date_string_parser_validator.sv
// Date string parser and validator, top level.
// The result beat is presented in the cycle after the terminator beat.
// Throughput: one input beat per cycle; a character beat is taken while a
// result waits, as long as the single output register is free or being drained.
// Reset clears the parse state, sets the stored date to 1/1/1900 and empties
// the output register.
module date_string_parser_validator
  import dsp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ChW-1:0]      s_tdata,  // [7:0] ch
  input  logic                s_tuser,  // [0] end_marker
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,  // [4:0] out_day, [8:5] out_month, [22:9] out_year, [23] zero
  output logic                m_tuser   // [0] date_valid
);

  logic             beat, term;
  parse_t           cur;
  check_t           res;
  logic [DayW-1:0]  stored_day;
  logic [MonW-1:0]  stored_month;
  logic [YearW-1:0] stored_year;
  logic [DayW-1:0]  day_next;
  logic [MonW-1:0]  month_next;
  logic [YearW-1:0] year_next;
  logic             out_valid;
  logic             out_ok;
  logic [DayW-1:0]  out_day;
  logic [MonW-1:0]  out_month;
  logic [YearW-1:0] out_year;

  assign s_tready = !out_valid || m_tready;
  assign beat     = s_tvalid && s_tready;
  assign term     = beat && s_tuser;

  dsp_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .ch         (s_tdata),
    .end_marker (s_tuser),
    .cur        (cur)
  );

  dsp_check u_check (
    .cur (cur),
    .res (res)
  );

  assign day_next   = res.ok ? res.day   : stored_day;
  assign month_next = res.ok ? res.month : stored_month;
  assign year_next  = res.ok ? res.year  : stored_year;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_day   <= DayW'(1);
      stored_month <= MonW'(1);
      stored_year  <= ResetYear;
      out_valid    <= 1'b0;
    end else begin
      if (term) begin
        stored_day   <= day_next;
        stored_month <= month_next;
        stored_year  <= year_next;
        out_valid    <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (term) begin
      out_ok    <= res.ok;
      out_day   <= day_next;
      out_month <= month_next;
      out_year  <= year_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_ok;
  assign m_tdata  = {1'b0, out_year, out_month, out_day};

endmodule
